// File: design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants for the text cursor character writer
// Holds the command kind codes, the register indexes, the configuration
// bundle and the write job that travels from the front part to the back part.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Cursor arithmetic width and tab spacing (tab spacing is a power of two).
  localparam int CURSOR_BITS = 16;
  localparam int TAB_STEP    = 8;

  // Field and register widths.
  localparam int KIND_W   = 3;
  localparam int CHAR_W   = 8;
  localparam int MOVE_W   = 16;
  localparam int COLOR_W  = 8;
  localparam int ADDR_W   = 32;
  localparam int DIM_W    = 11;
  localparam int STRIDE_W = 13;
  localparam int INDEX_W  = 3;
  localparam int DATA_W   = 32;

  // A written column or row lies below a DIM_W-bit count.
  localparam int PROD_W = DIM_W + STRIDE_W;

  // Small queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [COLOR_W-1:0] COLOR_RESET = 8'h0F;

  localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
  localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

  typedef enum logic [KIND_W-1:0] {
    KIND_CHAR  = 3'd0,
    KIND_SET   = 3'd1,
    KIND_ADD   = 3'd2,
    KIND_COLOR = 3'd3,
    KIND_HOME  = 3'd4
  } kind_t;

  typedef enum logic [INDEX_W-1:0] {
    REG_BASE    = 3'd0,
    REG_COLUMNS = 3'd1,
    REG_ROWS    = 3'd2,
    REG_STRIDE  = 3'd3,
    REG_MONO    = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic [ADDR_W-1:0]   base;
    logic [DIM_W-1:0]    columns;
    logic [DIM_W-1:0]    rows;
    logic [STRIDE_W-1:0] stride;
    logic                mono;
  } cfg_t;

  // One character write: row offset already multiplied out.
  typedef struct packed {
    logic [PROD_W-1:0]  row_offset;
    logic [DIM_W-1:0]   col;
    logic [CHAR_W-1:0]  ch;
    logic [COLOR_W-1:0] color;
  } job_t;

endpackage

// File: design/tcw_cmd_if.sv
// ----------------------------------------------------------------------------
// tcw_cmd_if: print command channel
// Valid/ready channel carrying one print command per transaction.
// ----------------------------------------------------------------------------
interface tcw_cmd_if;
  logic                              valid;
  logic                              ready;
  logic [tcw_pkg::KIND_W-1:0]        kind;
  logic [tcw_pkg::CHAR_W-1:0]        char_code;
  logic signed [tcw_pkg::MOVE_W-1:0] move_x;
  logic signed [tcw_pkg::MOVE_W-1:0] move_y;
  logic [tcw_pkg::COLOR_W-1:0]       new_color;

  modport source (output valid, kind, char_code, move_x, move_y, new_color,
                  input ready);
  modport sink (input valid, kind, char_code, move_x, move_y, new_color,
                output ready);
endinterface

// File: design/tcw_wr_if.sv
// ----------------------------------------------------------------------------
// tcw_wr_if: buffer byte write channel
// Valid/ready channel carrying one byte write per transaction.
// ----------------------------------------------------------------------------
interface tcw_wr_if;
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::ADDR_W-1:0]  write_address;
  logic [tcw_pkg::CHAR_W-1:0]  write_data;
  logic                        last_write;

  modport source (output valid, write_address, write_data, last_write,
                  input ready);
  modport sink (input valid, write_address, write_data, last_write,
                output ready);
endinterface

// File: design/tcw_cfg_if.sv
// ----------------------------------------------------------------------------
// tcw_cfg_if: register write channel
// Valid/ready channel carrying one register write per transaction.
// ----------------------------------------------------------------------------
interface tcw_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [tcw_pkg::INDEX_W-1:0] reg_index;
  logic [tcw_pkg::DATA_W-1:0]  reg_data;

  modport source (output valid, reg_index, reg_data, input ready);
  modport sink (input valid, reg_index, reg_data, output ready);
endinterface

// File: design/text_cursor_char_writer.sv
// ----------------------------------------------------------------------------
// text_cursor_char_writer: print commands to text buffer byte writes
// Keeps a console cursor and color and writes visible characters into a
// text screen buffer in mono or character-plus-attribute layout.
// ----------------------------------------------------------------------------
// A new command can be accepted every clock cycle as long as the two-entry
// job queue has room. Cursor moves, color changes, control characters and
// characters outside the screen produce no writes. A visible character in
// mono mode produces one byte write; in attribute mode it produces the
// character byte followed by the color byte at the next address, the second
// write carrying last_write. The output port issues at most one byte write
// per cycle, so in attribute mode a steady stream of visible characters
// settles at one command per two byte writes, and in mono mode at one per
// cycle while the write port is not stalled. The first write of a character
// goes into the job queue when its command is accepted and then into the
// registered write port. Registers are written over the cfg channel, which
// is always ready, and must only change while no command is still being
// processed.
// ----------------------------------------------------------------------------
module text_cursor_char_writer (
  input  logic        clk,
  input  logic        rst,
  tcw_cmd_if.sink     cmd,
  tcw_wr_if.source    wr,
  tcw_cfg_if.sink     cfg
);

  // Register file; reset values match a one-cell attribute-mode screen.
  tcw_pkg::cfg_t cfg_regs;

  // Queue signals between the front and back parts.
  tcw_pkg::job_t push_job;
  tcw_pkg::job_t head_job;
  logic          push;
  logic          pop;
  logic          q_full;
  logic          q_not_empty;

  // Register writes are always taken; unknown indexes are dropped.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.base    <= '0;
      cfg_regs.columns <= tcw_pkg::DIM_W'(1);
      cfg_regs.rows    <= tcw_pkg::DIM_W'(1);
      cfg_regs.stride  <= tcw_pkg::STRIDE_W'(2);
      cfg_regs.mono    <= 1'b0;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        tcw_pkg::REG_BASE:    cfg_regs.base    <= tcw_pkg::ADDR_W'(cfg.reg_data);
        tcw_pkg::REG_COLUMNS: cfg_regs.columns <= cfg.reg_data[tcw_pkg::DIM_W-1:0];
        tcw_pkg::REG_ROWS:    cfg_regs.rows    <= cfg.reg_data[tcw_pkg::DIM_W-1:0];
        tcw_pkg::REG_STRIDE:  cfg_regs.stride  <= cfg.reg_data[tcw_pkg::STRIDE_W-1:0];
        tcw_pkg::REG_MONO:    cfg_regs.mono    <= cfg.reg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Front part: command decode, cursor and color state, row offset multiply.
  tcw_front u_front (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_regs),
    .cmd    (cmd),
    .q_full (q_full),
    .push   (push),
    .job    (push_job)
  );

  // Queue that lets the front keep taking commands while writes drain.
  tcw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .din       (push_job),
    .pop       (pop),
    .dout      (head_job),
    .full      (q_full),
    .not_empty (q_not_empty)
  );

  // Back part: address add and one or two registered byte writes per job.
  tcw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg_regs),
    .job       (head_job),
    .job_valid (q_not_empty),
    .pop       (pop),
    .wr        (wr)
  );

endmodule

// File: design/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front: command front part
// Accepts print commands, keeps the cursor and color, and hands each
// visible character to the queue as a write job.
// ----------------------------------------------------------------------------
module tcw_front (
  input  logic              clk,
  input  logic              rst,
  input  tcw_pkg::cfg_t     cfg,
  tcw_cmd_if.sink           cmd,
  input  logic              q_full,
  output logic              push,
  output tcw_pkg::job_t     job
);

  localparam int CB    = tcw_pkg::CURSOR_BITS;
  localparam int CMP_W = CB + tcw_pkg::DIM_W + 1;

  localparam logic [CB-1:0] TAB_MASK = CB'(tcw_pkg::TAB_STEP - 1);

  logic [CB-1:0]               cursor_column, cursor_column_next;
  logic [CB-1:0]               cursor_row, cursor_row_next;
  logic [tcw_pkg::COLOR_W-1:0] current_color, current_color_next;
  logic                        accept;
  logic                        col_inside;
  logic                        row_inside;
  logic                        printable;

  assign cmd.ready = !q_full;
  assign accept    = cmd.valid && cmd.ready;

  // A cursor value is on screen when it is non-negative and below the count.
  assign col_inside = !cursor_column[CB-1] &&
                      (CMP_W'(cursor_column) < CMP_W'(cfg.columns));
  assign row_inside = !cursor_row[CB-1] &&
                      (CMP_W'(cursor_row) < CMP_W'(cfg.rows));

  assign printable = (cmd.kind == tcw_pkg::KIND_CHAR) &&
                     (cmd.char_code != tcw_pkg::CH_CR) &&
                     (cmd.char_code != tcw_pkg::CH_LF) &&
                     (cmd.char_code != tcw_pkg::CH_TAB);

  assign push = accept && printable && col_inside && row_inside;

  always_comb begin
    job.row_offset = tcw_pkg::PROD_W'(tcw_pkg::DIM_W'(cursor_row)) *
                     tcw_pkg::PROD_W'(cfg.stride);
    job.col        = tcw_pkg::DIM_W'(cursor_column);
    job.ch         = cmd.char_code;
    job.color      = current_color;
  end

  always_comb begin
    cursor_column_next = cursor_column;
    cursor_row_next    = cursor_row;
    current_color_next = current_color;
    unique case (cmd.kind)
      tcw_pkg::KIND_CHAR: begin
        if (cmd.char_code == tcw_pkg::CH_CR) begin
          cursor_column_next = '0;
        end else if (cmd.char_code == tcw_pkg::CH_LF) begin
          cursor_column_next = '0;
          cursor_row_next    = cursor_row + CB'(1);
        end else if (cmd.char_code == tcw_pkg::CH_TAB) begin
          cursor_column_next = (cursor_column + TAB_MASK) & ~TAB_MASK;
        end else begin
          cursor_column_next = cursor_column + CB'(1);
        end
      end
      tcw_pkg::KIND_SET: begin
        cursor_column_next = CB'(cmd.move_x);
        cursor_row_next    = CB'(cmd.move_y);
      end
      tcw_pkg::KIND_ADD: begin
        cursor_column_next = cursor_column + CB'(cmd.move_x);
        cursor_row_next    = cursor_row + CB'(cmd.move_y);
      end
      tcw_pkg::KIND_COLOR: begin
        current_color_next = cmd.new_color;
      end
      tcw_pkg::KIND_HOME: begin
        cursor_column_next = '0;
        cursor_row_next    = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_column <= '0;
      cursor_row    <= '0;
      current_color <= tcw_pkg::COLOR_RESET;
    end else if (accept) begin
      cursor_column <= cursor_column_next;
      cursor_row    <= cursor_row_next;
      current_color <= current_color_next;
    end
  end

endmodule

// File: design/tcw_queue.sv
// ----------------------------------------------------------------------------
// tcw_queue: write job queue
// A two-entry first-in first-out queue of write jobs between the front and
// back parts.
// ----------------------------------------------------------------------------
module tcw_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tcw_pkg::job_t din,
  input  logic          pop,
  output tcw_pkg::job_t dout,
  output logic          full,
  output logic          not_empty
);

  tcw_pkg::job_t              mem [tcw_pkg::QUEUE_DEPTH];
  logic [tcw_pkg::QPTR_W-1:0] wr_ptr;
  logic [tcw_pkg::QPTR_W-1:0] rd_ptr;
  logic [tcw_pkg::QPTR_W:0]   count;

  assign full      = (count == (tcw_pkg::QPTR_W + 1)'(tcw_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign dout      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + tcw_pkg::QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + tcw_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (tcw_pkg::QPTR_W + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (tcw_pkg::QPTR_W + 1)'(1);
      end
    end
  end

endmodule

// File: design/tcw_back.sv
// ----------------------------------------------------------------------------
// tcw_back: byte write back part
// Takes write jobs from the queue and issues one or two byte writes each
// through a registered output stage.
// ----------------------------------------------------------------------------
module tcw_back (
  input  logic          clk,
  input  logic          rst,
  input  tcw_pkg::cfg_t cfg,
  input  tcw_pkg::job_t job,
  input  logic          job_valid,
  output logic          pop,
  tcw_wr_if.source      wr
);

  typedef enum logic {
    PH_FIRST,
    PH_SECOND
  } phase_t;

  phase_t                     phase;
  logic                       load;
  logic [tcw_pkg::ADDR_W-1:0] first_address;
  logic [tcw_pkg::ADDR_W-1:0] col_offset;

  assign load = !wr.valid || wr.ready;

  // Attribute mode stores two bytes per cell.
  assign col_offset = cfg.mono ? tcw_pkg::ADDR_W'(job.col)
                               : tcw_pkg::ADDR_W'({job.col, 1'b0});
  assign first_address = cfg.base + tcw_pkg::ADDR_W'(job.row_offset) + col_offset;

  assign pop = load && ((phase == PH_SECOND) ||
                        (phase == PH_FIRST && job_valid && cfg.mono));

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_FIRST;
      wr.valid <= 1'b0;
    end else if (load) begin
      unique case (phase)
        PH_SECOND: begin
          wr.valid         <= 1'b1;
          wr.write_address <= wr.write_address + tcw_pkg::ADDR_W'(1);
          wr.write_data    <= job.color;
          wr.last_write    <= 1'b1;
          phase            <= PH_FIRST;
        end
        PH_FIRST: begin
          if (job_valid) begin
            wr.valid         <= 1'b1;
            wr.write_address <= first_address;
            wr.write_data    <= job.ch;
            wr.last_write    <= cfg.mono;
            phase            <= cfg.mono ? PH_FIRST : PH_SECOND;
          end else begin
            wr.valid <= 1'b0;
          end
        end
        default: begin
          phase <= PH_FIRST;
        end
      endcase
    end
  end

endmodule

// File: tb/tcw_buffer_write_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_buffer_write_check: predicts and compares text buffer byte writes
// Watches the register, command and write channels of the cursor writer,
// keeps its own cursor, color and screen setup, and checks every byte write
// against the oldest predicted one.
// ----------------------------------------------------------------------------
module tcw_buffer_write_check
  import tcw_pkg::*;
(
  input  logic clk,
  input  logic rst,
  tcw_cmd_if   cmd,
  tcw_wr_if    wr,
  tcw_cfg_if   cfg,
  output int   mismatches,
  output int   writes_waiting,
  output int   writes_matched
);

  localparam logic [CURSOR_BITS-1:0] TAB_MASK = CURSOR_BITS'(TAB_STEP - 1);

  typedef struct {
    logic [ADDR_W-1:0] address;
    logic [CHAR_W-1:0] data;
    logic              last;
  } byte_write_t;

  byte_write_t            expected_writes[$];
  cfg_t                   screen;
  logic [CURSOR_BITS-1:0] cursor_col;
  logic [CURSOR_BITS-1:0] cursor_row;
  logic [COLOR_W-1:0]     attr_byte;

  // A negative cursor value is never on the screen.
  function automatic bit on_screen(input logic [CURSOR_BITS-1:0] pos,
                                   input logic [DIM_W-1:0] limit);
    return !pos[CURSOR_BITS-1] && (32'(pos) < 32'(limit));
  endfunction

  task automatic record_register(input logic [INDEX_W-1:0] index,
                                 input logic [DATA_W-1:0] value);
    case (index)
      REG_BASE:    screen.base    = value[ADDR_W-1:0];
      REG_COLUMNS: screen.columns = value[DIM_W-1:0];
      REG_ROWS:    screen.rows    = value[DIM_W-1:0];
      REG_STRIDE:  screen.stride  = value[STRIDE_W-1:0];
      REG_MONO:    screen.mono    = value[0];
      default: ;
    endcase
  endtask

  task automatic predict_command(input logic [KIND_W-1:0] op,
                                 input logic [CHAR_W-1:0] code,
                                 input logic [MOVE_W-1:0] dx,
                                 input logic [MOVE_W-1:0] dy,
                                 input logic [COLOR_W-1:0] attr);
    byte_write_t       w;
    logic [ADDR_W-1:0] row_start;
    case (op)
      KIND_CHAR: begin
        if (code == CH_CR) begin
          cursor_col = '0;
        end else if (code == CH_LF) begin
          cursor_col = '0;
          cursor_row = cursor_row + 1'b1;
        end else if (code == CH_TAB) begin
          cursor_col = (cursor_col + TAB_MASK) & ~TAB_MASK;
        end else begin
          if (on_screen(cursor_col, screen.columns) && on_screen(cursor_row, screen.rows)) begin
            row_start = screen.base + ADDR_W'(cursor_row) * ADDR_W'(screen.stride);
            w.data = code;
            if (screen.mono) begin
              w.address = row_start + ADDR_W'(cursor_col);
              w.last    = 1'b1;
              expected_writes.push_back(w);
            end else begin
              w.address = row_start + (ADDR_W'(cursor_col) << 1);
              w.last    = 1'b0;
              expected_writes.push_back(w);
              w.address = w.address + 1'b1;
              w.data    = attr_byte;
              w.last    = 1'b1;
              expected_writes.push_back(w);
            end
          end
          cursor_col = cursor_col + 1'b1;
        end
      end
      KIND_SET: begin
        cursor_col = dx;
        cursor_row = dy;
      end
      KIND_ADD: begin
        cursor_col = cursor_col + dx;
        cursor_row = cursor_row + dy;
      end
      KIND_COLOR: attr_byte = attr;
      KIND_HOME: begin
        cursor_col = '0;
        cursor_row = '0;
      end
      default: ;
    endcase
  endtask

  task automatic check_write();
    byte_write_t want;
    if (expected_writes.size() == 0) begin
      $error("unexpected write: write_address %h write_data %h last_write %b",
             wr.write_address, wr.write_data, wr.last_write);
      mismatches++;
      return;
    end
    want = expected_writes.pop_front();
    if (wr.write_address !== want.address) begin
      $error("write_address: expected %h, actual %h", want.address, wr.write_address);
      mismatches++;
    end
    if (wr.write_data !== want.data) begin
      $error("write_data: expected %h, actual %h", want.data, wr.write_data);
      mismatches++;
    end
    if (wr.last_write !== want.last) begin
      $error("last_write: expected %b, actual %b", want.last, wr.last_write);
      mismatches++;
    end
    writes_matched++;
  endtask

  // Channels are sampled at the rising edge, before the block's own updates.
  always @(posedge clk) begin
    if (rst) begin
      expected_writes.delete();
      screen.base    = '0;
      screen.columns = DIM_W'(1);
      screen.rows    = DIM_W'(1);
      screen.stride  = STRIDE_W'(2);
      screen.mono    = 1'b0;
      cursor_col     = '0;
      cursor_row     = '0;
      attr_byte      = COLOR_RESET;
    end else begin
      if (cfg.valid && cfg.ready)
        record_register(cfg.reg_index, cfg.reg_data);
      // Writes are compared before new predictions are queued at the same edge.
      if (wr.valid && wr.ready)
        check_write();
      if (cmd.valid && cmd.ready)
        predict_command(cmd.kind, cmd.char_code, cmd.move_x, cmd.move_y, cmd.new_color);
    end
    writes_waiting = expected_writes.size();
  end

endmodule

// File: tb/tb_text_cursor_char_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_cursor_char_writer: testbench top for the text cursor writer
// Drives print commands and register writes, stalls the write port at
// random and in long stretches, and leaves prediction and comparison to the
// buffer write checker instantiated next to the block.
// ----------------------------------------------------------------------------
module tb_text_cursor_char_writer;
  import tcw_pkg::*;

  // Random commands, spread evenly over the screen setups below.
  localparam int RANDOM_ITEMS     = 1625;
  localparam int SCREEN_SETUPS    = 8;
  // Commands that write nothing take effect as they are accepted, so nothing
  // is left in flight once the last write has gone out; the settle wait is
  // only a margin.
  localparam int SETTLE_CYCLES    = 8;
  localparam int LONG_HOLD_CYCLES = 200;

  // Command kinds and register indexes that the block must ignore.
  localparam logic [KIND_W-1:0]  KIND_SPARE_FIRST = KIND_W'(int'(KIND_HOME) + 1);
  localparam logic [KIND_W-1:0]  KIND_SPARE_LAST  = '1;
  localparam logic [INDEX_W-1:0] REG_SPARE_FIRST  = INDEX_W'(int'(REG_MONO) + 1);
  localparam logic [INDEX_W-1:0] REG_SPARE_LAST   = '1;

  logic clk;
  logic rst;

  tcw_cmd_if cmd_ch ();
  tcw_wr_if  wr_ch ();
  tcw_cfg_if cfg_ch ();

  int mismatches;
  int writes_waiting;
  int writes_matched;

  // Percentages of cycles in which each side idles; changed as the run moves on.
  int send_idle_pct;
  int recv_idle_pct;

  // The stimulus asks for a long receiver hold-off by bumping hold_requests;
  // the receiver process serves each request and counts the cycles itself.
  int hold_requests;
  int hold_served;
  int hold_left;

  // Screen size as the stimulus sees it, used only to aim cursor moves.
  int shape_cols;
  int shape_rows;

  int commands_sent;
  int directed_count;
  int setups_applied;

  text_cursor_char_writer dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .wr  (wr_ch),
    .cfg (cfg_ch)
  );

  tcw_buffer_write_check write_check (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd_ch),
    .wr             (wr_ch),
    .cfg            (cfg_ch),
    .mismatches     (mismatches),
    .writes_waiting (writes_waiting),
    .writes_matched (writes_matched)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Hard stop in case the block hangs or loses a write.
  initial begin
    #4ms;
    $display("text_cursor_char_writer test failed");
    $finish;
  end

  // Receiver: random back-pressure on the write port, plus long hold-offs on
  // request so that the job queue fills and the command port stalls.
  initial begin
    wr_ch.ready = 1'b0;
    hold_served = 0;
    hold_left   = 0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        wr_ch.ready <= 1'b0;
      end else if (hold_served != hold_requests) begin
        hold_served++;
        hold_left = LONG_HOLD_CYCLES - 1;
        wr_ch.ready <= 1'b0;
      end else begin
        wr_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // One command transaction. Inputs change at the falling edge; acceptance
  // is seen at the rising edge. Valid stays high on return so that a
  // following command goes out back to back; anything else lowers it first.
  task automatic send_command(input logic [KIND_W-1:0] op,
                              input logic [CHAR_W-1:0] code,
                              input logic [MOVE_W-1:0] dx,
                              input logic [MOVE_W-1:0] dy,
                              input logic [COLOR_W-1:0] attr);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(negedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.kind      <= op;
    cmd_ch.char_code <= code;
    cmd_ch.move_x    <= dx;
    cmd_ch.move_y    <= dy;
    cmd_ch.new_color <= attr;
    do @(posedge clk); while (!cmd_ch.ready);
    commands_sent++;
  endtask

  // Stop sending and wait until every predicted write has come out, then
  // idle for the settle time; commands that write nothing are already done.
  task automatic wait_for_writes();
    @(negedge clk);
    cmd_ch.valid <= 1'b0;
    while (writes_waiting != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [INDEX_W-1:0] index,
                                input logic [DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= index;
    cfg_ch.reg_data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Writes all five registers. With junk_high set, the bits above each
  // narrow register are filled with noise, which the block must drop.
  task automatic apply_screen(input logic [ADDR_W-1:0] base, input int columns,
                              input int rows, input int stride, input bit mono,
                              input bit junk_high);
    logic [DATA_W-1:0] noise;
    noise = junk_high ? DATA_W'($urandom) : '0;
    shape_cols = columns;
    shape_rows = rows;
    write_register(REG_BASE, base);
    write_register(REG_COLUMNS, {noise[DATA_W-1:DIM_W], DIM_W'(columns)});
    write_register(REG_ROWS, {noise[DATA_W-1:DIM_W], DIM_W'(rows)});
    write_register(REG_STRIDE, {noise[DATA_W-1:STRIDE_W], STRIDE_W'(stride)});
    write_register(REG_MONO, {noise[DATA_W-1:1], mono});
    setups_applied++;
  endtask

  // Mostly printable text at cursor positions aimed inside the screen, with
  // control characters, relative moves, color changes, homes and a little
  // noise of unused kinds. Every payload field carries random bits.
  task automatic send_random_command();
    int                  pick;
    logic [KIND_W-1:0]   op;
    logic [CHAR_W-1:0]   code;
    logic [MOVE_W-1:0]   dx;
    logic [MOVE_W-1:0]   dy;
    logic [COLOR_W-1:0]  attr;
    pick = $urandom_range(99);
    code = CHAR_W'($urandom);
    dx   = MOVE_W'($urandom);
    dy   = MOVE_W'($urandom);
    attr = COLOR_W'($urandom);
    if (pick < 60) begin
      op   = KIND_CHAR;
      pick = $urandom_range(99);
      if (pick < 5)
        code = CH_CR;
      else if (pick < 9)
        code = CH_LF;
      else if (pick < 13)
        code = CH_TAB;
    end else if (pick < 72) begin
      op = KIND_SET;
      // Aim just inside or just past the screen most of the time.
      if ($urandom_range(9) < 8) begin
        dx = MOVE_W'($urandom_range(shape_cols + 2));
        dy = MOVE_W'($urandom_range(shape_rows + 1));
      end
    end else if (pick < 82) begin
      op = KIND_ADD;
      if ($urandom_range(3) != 0) begin
        dx = MOVE_W'($urandom_range(8)) - MOVE_W'(4);
        dy = MOVE_W'($urandom_range(2)) - MOVE_W'(1);
      end
    end else if (pick < 90) begin
      op = KIND_COLOR;
    end else if (pick < 96) begin
      op = KIND_HOME;
    end else begin
      op = KIND_W'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST));
    end
    send_command(op, code, dx, dy, attr);
  endtask

  // Short walk through the corner cases: the reset setup first, then an
  // 80x25 attribute screen whose base sits just below the top of the
  // address space so that the bottom-right cell wraps around.
  task automatic run_directed();
    send_command(KIND_CHAR, 8'h41, '0, '0, '0);       // visible at the origin
    send_command(KIND_CHAR, 8'h00, '0, '0, '0);       // column 1 is off a 1x1 screen
    send_command(KIND_CHAR, CH_CR, '0, '0, '0);
    send_command(KIND_COLOR, '0, '0, '0, 8'hFF);
    send_command(KIND_CHAR, 8'hFF, '1, '1, '1);       // written with the new color
    send_command(KIND_CHAR, CH_LF, '0, '0, '0);
    send_command(KIND_CHAR, 8'h42, '0, '0, '0);       // row 1 is off screen
    send_command(KIND_HOME, '1, '1, '1, '1);
    send_command(KIND_COLOR, '0, '0, '0, 8'h00);
    wait_for_writes();
    apply_screen(32'hFFFF_FFF0, 80, 25, 160, 1'b0, 1'b0);
    send_command(KIND_SET, '0, MOVE_W'(79), MOVE_W'(24), '0);
    send_command(KIND_CHAR, 8'h78, '0, '0, '0);       // last cell, address wraps
    send_command(KIND_CHAR, 8'h79, '0, '0, '0);       // one past the right edge
    // Most negative column and most positive row: off screen both ways.
    send_command(KIND_SET, '0, MOVE_W'(16'h8000), MOVE_W'(16'h7FFF), '0);
    send_command(KIND_CHAR, CH_TAB, '0, '0, '0);      // already on a tab stop
    send_command(KIND_ADD, '0, MOVE_W'(16'hFFFF), MOVE_W'(16'h8000), '0);
    send_command(KIND_CHAR, CH_TAB, '0, '0, '0);      // rounds up past the sign wrap
    send_command(KIND_SET, '0, MOVE_W'(16'hFFFD), '0, '0);
    send_command(KIND_CHAR, CH_TAB, '0, '0, '0);      // negative column rounds to zero
    send_command(KIND_CHAR, 8'h7E, '0, '0, '0);
    for (int k = int'(KIND_SPARE_FIRST); k <= int'(KIND_SPARE_LAST); k++)
      send_command(KIND_W'(k), CHAR_W'($urandom), MOVE_W'($urandom),
                   MOVE_W'($urandom), COLOR_W'($urandom));
    send_command(KIND_SET, '0, MOVE_W'(5), MOVE_W'(3), '0);
    send_command(KIND_CHAR, CH_TAB, '0, '0, '0);
    send_command(KIND_CHAR, 8'h2A, '0, '0, '0);
  endtask

  task automatic run_random();
    int n;
    n = 0;
    for (int s = 0; s < SCREEN_SETUPS; s++) begin
      wait_for_writes();
      case (s)
        0: apply_screen(32'h0000_0000, 80, 25, 160, 1'b0, 1'b0);
        1: apply_screen(32'hFFFF_FF00, 1024, 1024, 4096, 1'b1, 1'b0);
        2: apply_screen(ADDR_W'($urandom), 1, 1, 1, 1'b0, 1'b0);
        3: apply_screen(ADDR_W'($urandom), 40, 12, 8191, 1'b0, 1'b0);
        4: apply_screen(ADDR_W'($urandom), 2047, 3, 2, 1'b1, 1'b0);
        5: begin
          // No columns at all; also poke the unused register indexes.
          apply_screen(ADDR_W'($urandom), 0, 6, 100, 1'($urandom_range(1)), 1'b0);
          for (int r = int'(REG_SPARE_FIRST); r <= int'(REG_SPARE_LAST); r++)
            write_register(INDEX_W'(r), DATA_W'($urandom));
        end
        6: apply_screen(ADDR_W'($urandom), 9, 0, 50, 1'($urandom_range(1)), 1'b0);
        default: apply_screen(ADDR_W'($urandom), $urandom_range(1024, 1),
                              $urandom_range(1024, 1), $urandom_range(4096, 1),
                              1'($urandom_range(1)), 1'b1);
      endcase
      for (int k = 0; k < RANDOM_ITEMS / SCREEN_SETUPS; k++) begin
        // Sender light and receiver heavy, then the reverse, then no idling.
        if (n < RANDOM_ITEMS / 3) begin
          send_idle_pct = 13;
          recv_idle_pct = 60;
        end else if (n < 2 * RANDOM_ITEMS / 3) begin
          send_idle_pct = 60;
          recv_idle_pct = 13;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        if (n == 100 || n == 1450)
          hold_requests++;
        if (n == 700)
          wait_for_writes();
        send_random_command();
        n++;
      end
    end
  endtask

  initial begin
    rst              = 1'b1;
    cmd_ch.valid     = 1'b0;
    cmd_ch.kind      = '0;
    cmd_ch.char_code = '0;
    cmd_ch.move_x    = '0;
    cmd_ch.move_y    = '0;
    cmd_ch.new_color = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.reg_index = '0;
    cfg_ch.reg_data  = '0;
    send_idle_pct    = 13;
    recv_idle_pct    = 60;
    hold_requests    = 0;
    shape_cols       = 1;
    shape_rows       = 1;
    commands_sent    = 0;
    setups_applied   = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    run_directed();
    directed_count = commands_sent;
    run_random();
    wait_for_writes();

    $display("Covered %0d print commands (%0d directed) over %0d screen setups.",
             commands_sent, directed_count, setups_applied);
    $display("Compared %0d byte writes in mono and attribute layouts, %0d mismatches.",
             writes_matched, mismatches);
    if (mismatches == 0)
      $display("text_cursor_char_writer test passed");
    else
      $display("text_cursor_char_writer test failed");
    $finish;
  end

endmodule

// File: text_cursor_char_writer.f
design/tcw_pkg.sv
design/tcw_cmd_if.sv
design/tcw_wr_if.sv
design/tcw_cfg_if.sv
design/tcw_front.sv
design/tcw_queue.sv
design/tcw_back.sv
design/text_cursor_char_writer.sv
tb/tcw_buffer_write_check.sv
tb/tb_text_cursor_char_writer.sv
